// ===== sv/rwp_pkg.sv =====
package rwp_pkg;

	localparam int unsigned SMP_W  = 24;
	localparam int unsigned RATE_W = 18;
	localparam int unsigned CODE_W = 4;

	localparam logic [1:0] CFG_TOTAL_LENGTH = 2'd0;
	localparam logic [1:0] CFG_BYTE_LIMIT   = 2'd1;
	localparam logic [1:0] CFG_FRAME_LIMIT  = 2'd2;

	localparam logic [CODE_W-1:0] ST_OK          = 4'd0;
	localparam logic [CODE_W-1:0] ST_TOO_LARGE   = 4'd1;
	localparam logic [CODE_W-1:0] ST_NOT_WAVE    = 4'd2;
	localparam logic [CODE_W-1:0] ST_OVERRUN     = 4'd3;
	localparam logic [CODE_W-1:0] ST_TWO_FMT     = 4'd4;
	localparam logic [CODE_W-1:0] ST_BAD_FMT     = 4'd5;
	localparam logic [CODE_W-1:0] ST_TWO_DATA    = 4'd6;
	localparam logic [CODE_W-1:0] ST_MISSING     = 4'd7;
	localparam logic [CODE_W-1:0] ST_PARTIAL     = 4'd8;
	localparam logic [CODE_W-1:0] ST_TOO_LONG    = 4'd9;
	localparam logic [CODE_W-1:0] ST_DATA_FIRST  = 4'd10;

	localparam int unsigned OUT_DATA_W = 56;

	typedef enum logic [2:0] {
		PH_HEADER,
		PH_CHDR,
		PH_FMT,
		PH_DATA,
		PH_SKIP,
		PH_PAD,
		PH_DONE
	} phase_t;

	typedef struct packed {
		logic                     smp_v;
		logic signed [SMP_W-1:0]  smp;
		logic                     chan;
		logic                     st_v;
		logic [CODE_W-1:0]        code;
		logic [1:0]               cc;
		logic [RATE_W-1:0]        rate;
	} event_t;

endpackage

// ===== sv/rwp_fifo.sv =====
module rwp_fifo #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             full,
	output logic             empty
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wptr_q, rptr_q;
	logic [CW-1:0]    cnt_q;

	function automatic logic [AW-1:0] nxt(input logic [AW-1:0] p);
		return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
	endfunction

	assign full  = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wptr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push)
				wptr_q <= nxt(wptr_q);
			if (pop)
				rptr_q <= nxt(rptr_q);
			if (push && !pop)
				cnt_q <= cnt_q + CW'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - CW'(1);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n) !(push && full))
		else $error("push into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n) !(pop && empty))
		else $error("pop from empty queue");
	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> !empty)
		else $error("queue lost an entry");

endmodule

// ===== sv/rwp_front.sv =====
module rwp_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [1:0]            cfg_idx,
	input  logic [31:0]           cfg_wdata,
	input  logic                  byte_go,
	input  logic [7:0]            byte_in,
	output logic                  ev_push,
	output rwp_pkg::event_t       ev
);

	localparam logic [31:0] TAG_FMT  = 32'h666D7420;
	localparam logic [31:0] TAG_DATA = 32'h64617461;

	logic [31:0] total_q, blim_q, flim_q;
	rwp_pkg::phase_t phase_q, phase_n;
	logic [31:0] rem_q, rem_n;
	logic [5:0]  off_q, off_n;
	logic [31:0] tag_q, tag_n;
	logic [31:0] csize_q, csize_n;
	logic        pad_q, pad_n;
	logic        fseen_q, fseen_n;
	logic        dseen_q, dseen_n;
	logic [15:0] words_q [8];
	logic [15:0] words_n [8];
	logic        gbad_q, gbad_n;
	logic [23:0] gath_q, gath_n;
	logic [1:0]  sbc_q, sbc_n;
	logic        chan_q, chan_n;
	logic [1:0]  r3_q, r3_n;
	logic [34:0] lf_q;

	logic [3:0]  err;
	logic        do_end;
	logic        active;
	logic [31:0] size_f;
	logic [23:0] gg;
	logic        divisible;
	logic        w24;
	logic [4:0]  dsum;

	function automatic logic [7:0] hdr_byte(input logic [3:0] p);
		unique case (p)
			4'd0:    return 8'h52;
			4'd1:    return 8'h49;
			4'd2:    return 8'h46;
			4'd3:    return 8'h46;
			4'd8:    return 8'h57;
			4'd9:    return 8'h41;
			4'd10:   return 8'h56;
			4'd11:   return 8'h45;
			default: return 8'h00;
		endcase
	endfunction

	function automatic logic [7:0] guid_byte(input logic [3:0] p);
		unique case (p)
			4'd0:    return 8'h01;
			4'd6:    return 8'h10;
			4'd8:    return 8'h80;
			4'd11:   return 8'hAA;
			4'd13:   return 8'h38;
			4'd14:   return 8'h9B;
			4'd15:   return 8'h71;
			default: return 8'h00;
		endcase
	endfunction

	function automatic logic [1:0] mod3(input logic [4:0] v);
		unique case (v)
			5'd0, 5'd3, 5'd6, 5'd9, 5'd12, 5'd15:  return 2'd0;
			5'd1, 5'd4, 5'd7, 5'd10, 5'd13, 5'd16: return 2'd1;
			5'd2, 5'd5, 5'd8, 5'd11, 5'd14, 5'd17: return 2'd2;
			default:                               return 2'd0;
		endcase
	endfunction

	function automatic logic fmt_ok(input logic [5:0] o, input logic [15:0] w [8],
		input logic gb);
		logic [31:0] rate;
		logic [15:0] ch, bits, align;
		logic        ext;
		rate  = {w[3], w[2]};
		ch    = w[1];
		bits  = w[7];
		ext   = (w[0] == 16'hFFFE);
		align = (bits == 16'd16) ? {ch[14:0], 1'b0} : (ch + {ch[14:0], 1'b0});
		if (o < 6'd16)
			return 1'b0;
		if (ext && (o < 6'd40 || gb))
			return 1'b0;
		if (!ext && w[0] != 16'd1)
			return 1'b0;
		if (ch < 16'd1 || ch > 16'd2)
			return 1'b0;
		if (rate < 32'd8000 || rate > 32'd192000)
			return 1'b0;
		if (bits != 16'd16 && bits != 16'd24)
			return 1'b0;
		return w[6] == align;
	endfunction

	assign w24 = (words_q[7] == 16'd24);
	assign active = byte_go && (phase_q != rwp_pkg::PH_DONE) && (rem_q != '0);

	always_comb begin
		phase_n = phase_q;
		rem_n   = rem_q;
		off_n   = off_q;
		tag_n   = tag_q;
		csize_n = csize_q;
		pad_n   = pad_q;
		fseen_n = fseen_q;
		dseen_n = dseen_q;
		words_n = words_q;
		gbad_n  = gbad_q;
		gath_n  = gath_q;
		sbc_n   = sbc_q;
		chan_n  = chan_q;
		r3_n    = r3_q;
		err     = rwp_pkg::ST_OK;
		do_end  = 1'b0;
		size_f  = csize_q;
		gg      = gath_q;
		divisible = 1'b0;
		dsum    = 5'({3'b0, byte_in[1:0]}) + 5'(byte_in[3:2]) + 5'(byte_in[5:4])
			+ 5'(byte_in[7:6]) + 5'(r3_q);
		ev      = '0;
		ev_push = 1'b0;

		if (active) begin
			rem_n = rem_q - 32'd1;
			unique case (phase_q)
				rwp_pkg::PH_HEADER: begin
					if (off_q == 6'd0 && total_q > blim_q)
						err = rwp_pkg::ST_TOO_LARGE;
					else if (off_q == 6'd0 && total_q < 32'd12)
						err = rwp_pkg::ST_NOT_WAVE;
					else if ((off_q < 6'd4 || off_q >= 6'd8) && byte_in != hdr_byte(off_q[3:0]))
						err = rwp_pkg::ST_NOT_WAVE;
					if (off_q >= 6'd11) begin
						phase_n = rwp_pkg::PH_CHDR;
						off_n   = '0;
					end else
						off_n = off_q + 6'd1;
				end
				rwp_pkg::PH_CHDR: begin
					off_n = off_q + 6'd1;
					if (off_q < 6'd4) begin
						tag_n = {tag_q[23:0], byte_in};
						r3_n  = '0;
					end else begin
						r3_n = mod3(dsum);
						unique case (off_q[1:0])
							2'd0: size_f[7:0]   = byte_in;
							2'd1: size_f[15:8]  = byte_in;
							2'd2: size_f[23:16] = byte_in;
							default: size_f[31:24] = byte_in;
						endcase
						csize_n = size_f;
					end
					if (off_q == 6'd7) begin
						unique case ({words_q[1][1], w24})
							2'b00: divisible = !size_f[0];
							2'b01: divisible = (r3_n == 2'd0);
							2'b10: divisible = (size_f[1:0] == 2'd0);
							default: divisible = !size_f[0] && (r3_n == 2'd0);
						endcase
						off_n = '0;
						if (size_f >= rem_q)
							err = rwp_pkg::ST_OVERRUN;
						else begin
							pad_n = size_f[0];
							if (tag_q == TAG_FMT) begin
								if (fseen_q)
									err = rwp_pkg::ST_TWO_FMT;
								else begin
									for (int i = 0; i < 8; i++)
										words_n[i] = '0;
									gbad_n  = 1'b0;
									phase_n = rwp_pkg::PH_FMT;
									if (size_f == '0)
										err = rwp_pkg::ST_BAD_FMT;
								end
							end else if (tag_q == TAG_DATA) begin
								if (dseen_q)
									err = rwp_pkg::ST_TWO_DATA;
								else if (!fseen_q)
									err = rwp_pkg::ST_DATA_FIRST;
								else if (!divisible)
									err = rwp_pkg::ST_PARTIAL;
								else if ({3'b0, size_f} > lf_q)
									err = rwp_pkg::ST_TOO_LONG;
								else begin
									dseen_n = 1'b1;
									gath_n  = '0;
									sbc_n   = '0;
									chan_n  = 1'b0;
									phase_n = rwp_pkg::PH_DATA;
									do_end  = (size_f == '0);
								end
							end else begin
								phase_n = rwp_pkg::PH_SKIP;
								do_end  = (size_f == '0);
							end
						end
					end
				end
				rwp_pkg::PH_FMT: begin
					if (off_q < 6'd16) begin
						if (off_q[0])
							words_n[off_q[3:1]][15:8] = byte_in;
						else
							words_n[off_q[3:1]][7:0] = byte_in;
					end else if (off_q == 6'd16)
						gath_n = {16'd0, byte_in};
					else if (off_q == 6'd17) begin
						if ({byte_in, gath_q[7:0]} < 16'd22)
							gbad_n = 1'b1;
					end else if (off_q >= 6'd24 && off_q < 6'd40) begin
						if (byte_in != guid_byte(4'(off_q - 6'd24)))
							gbad_n = 1'b1;
					end
					if (off_q < 6'd63)
						off_n = off_q + 6'd1;
					csize_n = csize_q - 32'd1;
					if (csize_q == 32'd1) begin
						do_end = 1'b1;
						if (fmt_ok(off_n, words_n, gbad_n))
							fseen_n = 1'b1;
						else
							err = rwp_pkg::ST_BAD_FMT;
					end
				end
				rwp_pkg::PH_DATA: begin
					gg = gath_q;
					unique case (sbc_q)
						2'd0: gg[7:0]   = byte_in;
						2'd1: gg[15:8]  = byte_in;
						default: gg[23:16] = byte_in;
					endcase
					gath_n = gg;
					sbc_n  = sbc_q + 2'd1;
					if (sbc_n >= (w24 ? 2'd3 : 2'd2)) begin
						ev.smp_v = 1'b1;
						ev.smp   = w24 ? gg : {gg[15:0], 8'd0};
						ev.chan  = chan_q;
						chan_n   = (words_q[1] == 16'd2) ? !chan_q : 1'b0;
						gath_n   = '0;
						sbc_n    = '0;
					end
					csize_n = csize_q - 32'd1;
					do_end  = (csize_q == 32'd1);
				end
				rwp_pkg::PH_SKIP: begin
					csize_n = csize_q - 32'd1;
					do_end  = (csize_q == 32'd1);
				end
				rwp_pkg::PH_PAD: begin
					pad_n   = 1'b0;
					off_n   = '0;
					phase_n = rwp_pkg::PH_CHDR;
				end
				default: ;
			endcase

			if (do_end) begin
				gath_n  = '0;
				off_n   = '0;
				tag_n   = '0;
				csize_n = '0;
				phase_n = pad_n ? rwp_pkg::PH_PAD : rwp_pkg::PH_CHDR;
			end

			if (err != rwp_pkg::ST_OK || rem_q == 32'd1) begin
				ev.st_v = 1'b1;
				ev.code = (err != rwp_pkg::ST_OK) ? err :
					((fseen_n && dseen_n) ? rwp_pkg::ST_OK : rwp_pkg::ST_MISSING);
				ev.cc   = fseen_n ? words_n[1][1:0] : 2'd0;
				ev.rate = fseen_n ? {words_n[3][1:0], words_n[2]} : '0;
				phase_n = rwp_pkg::PH_DONE;
			end
			ev_push = ev.smp_v || ev.st_v;
		end

		if (cfg_we && cfg_idx == rwp_pkg::CFG_TOTAL_LENGTH) begin
			phase_n = rwp_pkg::PH_HEADER;
			rem_n   = cfg_wdata;
			off_n   = '0;
			tag_n   = '0;
			csize_n = '0;
			pad_n   = 1'b0;
			fseen_n = 1'b0;
			dseen_n = 1'b0;
			for (int i = 0; i < 8; i++)
				words_n[i] = '0;
			gbad_n  = 1'b0;
			gath_n  = '0;
			sbc_n   = '0;
			chan_n  = 1'b0;
			r3_n    = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			blim_q  <= '1;
			flim_q  <= '1;
			phase_q <= rwp_pkg::PH_HEADER;
			rem_q   <= '0;
			off_q   <= '0;
			tag_q   <= '0;
			csize_q <= '0;
			pad_q   <= 1'b0;
			fseen_q <= 1'b0;
			dseen_q <= 1'b0;
			for (int i = 0; i < 8; i++)
				words_q[i] <= '0;
			gbad_q  <= 1'b0;
			gath_q  <= '0;
			sbc_q   <= '0;
			chan_q  <= 1'b0;
			r3_q    <= '0;
			lf_q    <= '0;
		end else begin
			if (cfg_we && cfg_idx == rwp_pkg::CFG_TOTAL_LENGTH)
				total_q <= cfg_wdata;
			if (cfg_we && cfg_idx == rwp_pkg::CFG_BYTE_LIMIT)
				blim_q <= cfg_wdata;
			if (cfg_we && cfg_idx == rwp_pkg::CFG_FRAME_LIMIT)
				flim_q <= cfg_wdata;
			phase_q <= phase_n;
			rem_q   <= rem_n;
			off_q   <= off_n;
			tag_q   <= tag_n;
			csize_q <= csize_n;
			pad_q   <= pad_n;
			fseen_q <= fseen_n;
			dseen_q <= dseen_n;
			words_q <= words_n;
			gbad_q  <= gbad_n;
			gath_q  <= gath_n;
			sbc_q   <= sbc_n;
			chan_q  <= chan_n;
			r3_q    <= r3_n;
			unique case ({words_q[1][1], w24})
				2'b00: lf_q <= {2'b0, flim_q, 1'b0};
				2'b01: lf_q <= {3'b0, flim_q} + {2'b0, flim_q, 1'b0};
				2'b10: lf_q <= {1'b0, flim_q, 2'b0};
				default: lf_q <= {2'b0, flim_q, 1'b0} + {1'b0, flim_q, 2'b0};
			endcase
		end
	end

endmodule

// ===== sv/rwp_back.sv =====
module rwp_back (
	input  logic                                clk,
	input  logic                                arst_n,
	input  rwp_pkg::event_t                     head,
	input  logic                                empty,
	output logic                                pop,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	output logic [rwp_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
	output logic                                m_axis_tuser,
	output logic                                m_axis_tlast
);

	rwp_pkg::event_t ent_q;
	logic            psmp_q, pst_q;
	logic            xfer, fin;

	assign m_axis_tvalid = psmp_q || pst_q;
	assign xfer          = m_axis_tvalid && m_axis_tready;
	assign fin           = xfer && !(psmp_q && pst_q);
	assign pop           = (!m_axis_tvalid || fin) && !empty;

	assign m_axis_tuser  = !psmp_q;
	assign m_axis_tlast  = !psmp_q;
	assign m_axis_tdata  = psmp_q ?
		{7'd0, 18'd0, 2'd0, 4'd0, ent_q.chan, ent_q.smp} :
		{7'd0, ent_q.rate, ent_q.cc, ent_q.code, 1'b0, 24'd0};

	always_ff @(posedge clk) begin
		if (pop)
			ent_q <= head;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			psmp_q <= 1'b0;
			pst_q  <= 1'b0;
		end else if (pop) begin
			psmp_q <= head.smp_v;
			pst_q  <= head.st_v;
		end else if (xfer) begin
			if (psmp_q)
				psmp_q <= 1'b0;
			else
				pst_q <= 1'b0;
		end
	end

endmodule

// ===== sv/riff_wave_pcm_stream_parser.sv =====
// RIFF WAVE PCM parser: takes one file byte per cycle on s_axis while the event queue
// is not full and no cfg write is pending, and queues each decoded sample (Q1.23, channel
// index in tdata) when its last byte arrives, then one status transfer with tlast. A byte
// that completes both a sample and the file yields two output transfers, the sample
// first and then the status. A queue of FIFO_DEPTH events lets the parser run ahead of
// a stalled output. Write total_length (index 0) before each file; the write re-arms
// the parser. Samples sent before an error status should be discarded.
module riff_wave_pcm_stream_parser #(
	parameter int unsigned FIFO_DEPTH = 4
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [7:0]                         s_axis_tdata,  // file_byte
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// sample_value[23:0], channel_index[24], status_code[28:25],
	// channel_count[30:29], sample_rate[48:31], zero[55:49]
	output logic [rwp_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
	output logic                               m_axis_tuser,  // is_status
	output logic                               m_axis_tlast,  // last
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [1:0]                         cfg_index,
	input  logic [31:0]                        cfg_data
);

	localparam int unsigned EV_W = $bits(rwp_pkg::event_t);

	rwp_pkg::event_t ev, head;
	logic            ev_push, full, empty, pop, byte_go, cfg_we;

	assign cfg_ready     = 1'b1;
	assign cfg_we        = cfg_valid && cfg_ready;
	assign s_axis_tready = !full && !cfg_valid;
	assign byte_go       = s_axis_tvalid && s_axis_tready;

	rwp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_index),
		.cfg_wdata (cfg_data),
		.byte_go   (byte_go),
		.byte_in   (s_axis_tdata),
		.ev_push   (ev_push),
		.ev        (ev)
	);

	rwp_fifo #(
		.WIDTH (EV_W),
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (ev_push),
		.wdata  (ev),
		.pop    (pop),
		.rdata  (head),
		.full   (full),
		.empty  (empty)
	);

	rwp_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head),
		.empty         (empty),
		.pop           (pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

// ===== test/riff_wave_pcm_stream_parser_test.sv =====
`timescale 1ns / 1ps

module riff_wave_pcm_stream_parser_test;

	localparam logic [31:0] TAG_FMT  = 32'h666D7420;
	localparam logic [31:0] TAG_DATA = 32'h64617461;
	localparam logic [31:0] TAG_JUNK = 32'h4A554E4B;
	localparam logic [31:0] TAG_RIFF = 32'h52494646;
	localparam logic [31:0] TAG_WAVE = 32'h57415645;
	localparam int          IDLE_LIMIT = 4000;

	typedef struct {
		logic        st;
		logic [55:0] d;
	} wave_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [7:0] s_axis_tdata = 8'd0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [rwp_pkg::OUT_DATA_W-1:0] m_axis_tdata;
	logic m_axis_tuser;
	logic m_axis_tlast;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = rwp_pkg::CFG_TOTAL_LENGTH;
	logic [31:0] cfg_data = 32'd0;

	riff_wave_pcm_stream_parser dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	// parser state mirror
	logic [31:0] tot_len, byte_lim, frame_lim, pos, tag, remain;
	rwp_pkg::phase_t ph;
	int unsigned off;
	bit          pad, fmt_ok, data_ok, guid_bad;
	logic [15:0] fw [8];
	logic [23:0] gath;
	int unsigned nb;
	bit          chn;

	logic [7:0] hdr_ref  [16] = '{8'h52, 8'h49, 8'h46, 8'h46, 0, 0, 0, 0,
		8'h57, 8'h41, 8'h56, 8'h45, 0, 0, 0, 0};
	logic [7:0] guid_ref [16] = '{8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h10, 8'h00,
		8'h80, 8'h00, 8'h00, 8'hAA, 8'h00, 8'h38, 8'h9B, 8'h71};

	wave_result_t expected_q[$];
	logic [7:0]   file_q[$];
	int mismatches = 0, samples_seen = 0, statuses_seen = 0, files_run = 0;
	int burst_left = 0, rdy_mode = 0, idle_cycles = 0;
	bit gaps_on = 1'b0;

	function automatic void clear_parse();
		pos = 0; ph = rwp_pkg::PH_HEADER; tag = 0; remain = 0; off = 0; pad = 0;
		fmt_ok = 0; data_ok = 0; guid_bad = 0; gath = 0; nb = 0; chn = 0;
		foreach (fw[i]) fw[i] = 16'd0;
	endfunction

	function automatic void add_expected(wave_result_t r);
		expected_q.insert(expected_q.size(), r);
	endfunction

	function automatic void push_status(logic [3:0] code);
		wave_result_t r;
		logic [31:0] rate;
		rate = fmt_ok ? {fw[3], fw[2]} : 32'd0;
		r.st = 1'b1;
		r.d = {7'd0, rate[17:0], fmt_ok ? fw[1][1:0] : 2'd0, code, 1'b0, 24'd0};
		add_expected(r);
	endfunction

	function automatic bit fmt_good();
		logic [15:0] tg;
		logic [31:0] rate;
		int unsigned ch, bits;
		tg = fw[0];
		rate = {fw[3], fw[2]};
		ch = fw[1];
		bits = fw[7];
		if (off < 16) return 0;
		if (tg == 16'hFFFE) begin
			if (off < 40 || guid_bad) return 0;
			tg = 16'd1;
		end
		if (tg != 16'd1 || ch < 1 || ch > 2) return 0;
		if (rate < 8000 || rate > 192000) return 0;
		if (bits != 16 && bits != 24) return 0;
		return fw[6] == ch * bits / 8;
	endfunction

	function automatic logic [3:0] close_chunk();
		logic [3:0] e;
		e = rwp_pkg::ST_OK;
		if (ph == rwp_pkg::PH_FMT) begin
			if (fmt_good()) fmt_ok = 1;
			else e = rwp_pkg::ST_BAD_FMT;
		end
		gath = 0; off = 0; tag = 0; remain = 0;
		ph = pad ? rwp_pkg::PH_PAD : rwp_pkg::PH_CHDR;
		return e;
	endfunction

	function automatic logic [3:0] open_chunk();
		logic [31:0] frame;
		if (remain > tot_len - pos) return rwp_pkg::ST_OVERRUN;
		pad = remain[0];
		off = 0;
		if (tag == TAG_FMT) begin
			if (fmt_ok) return rwp_pkg::ST_TWO_FMT;
			foreach (fw[i]) fw[i] = 16'd0;
			guid_bad = 0;
			ph = rwp_pkg::PH_FMT;
		end else if (tag == TAG_DATA) begin
			if (data_ok) return rwp_pkg::ST_TWO_DATA;
			if (!fmt_ok) return rwp_pkg::ST_DATA_FIRST;
			frame = 32'(fw[1]) * 32'(fw[7] / 16'd8);
			if (frame == 0 || remain % frame != 0) return rwp_pkg::ST_PARTIAL;
			if (remain / frame > frame_lim) return rwp_pkg::ST_TOO_LONG;
			data_ok = 1; gath = 0; nb = 0; chn = 0;
			ph = rwp_pkg::PH_DATA;
		end else begin
			ph = rwp_pkg::PH_SKIP;
		end
		if (remain == 0) return close_chunk();
		return rwp_pkg::ST_OK;
	endfunction

	function automatic void take_fmt_byte(logic [7:0] b);
		if (off < 16) begin
			if (off[0]) fw[off >> 1][15:8] = b;
			else fw[off >> 1][7:0] = b;
		end else if (off == 16) begin
			gath = {16'd0, b};
		end else if (off == 17) begin
			if ({b, gath[7:0]} < 16'd22) guid_bad = 1;
		end else if (off >= 24 && off < 40) begin
			if (b != guid_ref[off - 24]) guid_bad = 1;
		end
		if (off < 63) off++;
	endfunction

	function automatic void parse_byte(logic [7:0] b);
		logic [3:0] err;
		logic [31:0] p;
		int unsigned w;
		wave_result_t r;
		err = rwp_pkg::ST_OK;
		if (ph == rwp_pkg::PH_DONE || pos >= tot_len) return;
		p = pos;
		pos++;
		case (ph)
			rwp_pkg::PH_HEADER: begin
				if (p == 0) begin
					if (tot_len > byte_lim) err = rwp_pkg::ST_TOO_LARGE;
					else if (tot_len < 12) err = rwp_pkg::ST_NOT_WAVE;
				end
				if (err == rwp_pkg::ST_OK && (p < 4 || p >= 8) && b != hdr_ref[p[3:0]])
					err = rwp_pkg::ST_NOT_WAVE;
				if (err == rwp_pkg::ST_OK && p >= 11) begin
					ph = rwp_pkg::PH_CHDR; off = 0;
				end
			end
			rwp_pkg::PH_CHDR: begin
				if (off < 4) tag = {tag[23:0], b};
				else remain |= 32'(b) << (8 * ((off - 4) & 3));
				off++;
				if (off >= 8) err = open_chunk();
			end
			rwp_pkg::PH_FMT: begin
				take_fmt_byte(b);
				remain--;
				if (remain == 0) err = close_chunk();
			end
			rwp_pkg::PH_DATA: begin
				w = fw[7] / 8;
				gath |= 24'(32'(b) << (8 * (nb & 3)));
				nb++;
				if (nb >= w) begin
					r.st = 1'b0;
					r.d = {31'd0, chn, (w == 2) ? {gath[15:0], 8'd0} : gath};
					add_expected(r);
					chn = (fw[1] == 16'd2) ? ~chn : 1'b0;
					gath = 0; nb = 0;
				end
				remain--;
				if (remain == 0) err = close_chunk();
			end
			rwp_pkg::PH_SKIP: begin
				remain--;
				if (remain == 0) err = close_chunk();
			end
			default: begin
				pad = 0; off = 0; ph = rwp_pkg::PH_CHDR;
			end
		endcase
		if (err != rwp_pkg::ST_OK) begin
			push_status(err);
			ph = rwp_pkg::PH_DONE;
		end else if (pos == tot_len) begin
			push_status((fmt_ok && data_ok) ? rwp_pkg::ST_OK : rwp_pkg::ST_MISSING);
			ph = rwp_pkg::PH_DONE;
		end
	endfunction

	// result checker
	always @(posedge clk) begin
		wave_result_t e;
		if (m_axis_tvalid && m_axis_tready) begin
			if (m_axis_tuser) statuses_seen++;
			else samples_seen++;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result user=%0b data=%h", m_axis_tuser, m_axis_tdata);
			end else begin
				e = expected_q.pop_front();
				if (m_axis_tuser !== e.st || m_axis_tlast !== e.st || m_axis_tdata !== e.d) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp user=%0b last=%0b data=%h, got %0b %0b %h",
							e.st, e.st, e.d, m_axis_tuser, m_axis_tlast, m_axis_tdata);
				end
			end
		end
		m_axis_tready <= (rdy_mode == 0) ? 1'b1 :
			($urandom_range(0, 99) < ((rdy_mode == 1) ? 70 : 25));
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(cfg_valid && cfg_ready) || !arst_n)
			idle_cycles <= 0;
		else if (idle_cycles >= IDLE_LIMIT) begin
			$display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
			$display("tb: failure");
			$finish;
		end else
			idle_cycles <= idle_cycles + 1;
	end

	task automatic send_byte(logic [7:0] b);
		if (gaps_on && burst_left == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = $urandom_range(1, 30);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		do @(posedge clk); while (!s_axis_tready);
		if (burst_left > 0) burst_left--;
		parse_byte(b);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [31:0] v);
		drain();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == rwp_pkg::CFG_TOTAL_LENGTH) begin
			tot_len = v;
			clear_parse();
		end else if (idx == rwp_pkg::CFG_BYTE_LIMIT) byte_lim = v;
		else if (idx == rwp_pkg::CFG_FRAME_LIMIT) frame_lim = v;
	endtask

	// arm with the given length, stream file_q, then some ignored bytes
	task automatic run_file(logic [31:0] len, int extra);
		drain();
		write_reg(rwp_pkg::CFG_TOTAL_LENGTH, len);
		foreach (file_q[i]) send_byte(file_q[i]);
		repeat (extra) send_byte(8'($urandom));
		files_run++;
	endtask

	function automatic void add_byte(logic [7:0] v);
		file_q.insert(file_q.size(), v);
	endfunction

	function automatic void put16(logic [15:0] v);
		add_byte(v[7:0]);
		add_byte(v[15:8]);
	endfunction

	function automatic void put32(logic [31:0] v);
		put16(v[15:0]);
		put16(v[31:16]);
	endfunction

	function automatic void put_tag(logic [31:0] t);
		add_byte(t[31:24]); add_byte(t[23:16]);
		add_byte(t[15:8]);  add_byte(t[7:0]);
	endfunction

	function automatic void put_header();
		file_q.delete();
		put_tag(TAG_RIFF);
		put32($urandom);
		put_tag(TAG_WAVE);
	endfunction

	function automatic void put_fmt(logic [15:0] ch, logic [31:0] rate, logic [15:0] bits,
			bit ext, logic [15:0] cb, bit guid_ok, int extra);
		logic [15:0] align;
		align = ch * bits / 16'd8;
		put_tag(TAG_FMT);
		put32((ext ? 40 : 16) + extra);
		put16(ext ? 16'hFFFE : 16'd1);
		put16(ch);
		put32(rate);
		put32(rate * align);
		put16(align);
		put16(bits);
		if (ext) begin
			put16(cb);
			put16(bits);
			put32(32'd3);
			foreach (guid_ref[i])
				add_byte((i == 14 && !guid_ok) ? 8'h9C : guid_ref[i]);
		end
		repeat (extra) add_byte(8'($urandom));
		if (extra % 2) add_byte(8'd0);
	endfunction

	function automatic void put_chunk(logic [31:0] t, int size, bit with_pad);
		put_tag(t);
		put32(size);
		repeat (size) add_byte(8'($urandom));
		if (with_pad && size % 2) add_byte(8'd0);
	endfunction

	task automatic test_valid_files();
		put_header();
		put_fmt(1, 8000, 16, 0, 0, 1, 0);
		put_tag(TAG_DATA); put32(8);
		put16(16'h0000); put16(16'hFFFF); put16(16'h8000); put16(16'h7FFF);
		run_file(file_q.size(), 2);
		put_header();
		put_chunk(TAG_JUNK, 3, 1);
		put_fmt(2, 192000, 24, 1, 22, 1, 1);
		put_tag(TAG_DATA); put32(12);
		put32(32'h7FFFFF00); put32(32'h00800000); put32(32'hFFFFFF80);
		put_chunk(TAG_JUNK, 5, 0);
		run_file(file_q.size(), 0);
		put_header();
		put_fmt(1, 48000, 24, 0, 0, 1, 0);
		put_chunk(TAG_DATA, 3, 1);
		repeat (5) add_byte(8'($urandom));
		run_file(file_q.size(), 0);
	endtask

	task automatic test_header_errors();
		put_header();
		file_q[3] = 8'h58;
		run_file(file_q.size(), 0);
		put_header();
		run_file(11, 0);
		write_reg(rwp_pkg::CFG_BYTE_LIMIT, 32'd20);
		put_header();
		put_fmt(1, 8000, 16, 0, 0, 1, 0);
		run_file(file_q.size(), 0);
		write_reg(rwp_pkg::CFG_BYTE_LIMIT, 32'd0);
		run_file(12, 0);
		write_reg(rwp_pkg::CFG_BYTE_LIMIT, 32'hFFFFFFFF);
		put_header();
		run_file(0, 0);
	endtask

	task automatic test_fmt_errors();
		put_header();
		put_fmt(1, 44100, 8, 0, 0, 1, 0);
		run_file(file_q.size(), 0);
		put_header();
		put_fmt(2, 7999, 16, 0, 0, 1, 0);
		run_file(file_q.size(), 0);
		put_header();
		put_fmt(1, 44100, 16, 1, 20, 1, 0);
		run_file(file_q.size(), 0);
		put_header();
		put_fmt(2, 96000, 24, 1, 22, 0, 0);
		run_file(file_q.size(), 0);
		put_header();
		put_fmt(1, 192001, 16, 0, 0, 1, 0);
		run_file(file_q.size(), 0);
		put_header();
		put_fmt(1, 44100, 16, 0, 0, 1, 0);
		put_fmt(1, 44100, 16, 0, 0, 1, 0);
		run_file(file_q.size(), 0);
	endtask

	task automatic test_chunk_errors();
		put_header();
		put_chunk(TAG_DATA, 4, 1);
		run_file(file_q.size(), 0);
		put_header();
		put_fmt(1, 22050, 16, 0, 0, 1, 0);
		put_chunk(TAG_DATA, 2, 1);
		put_chunk(TAG_DATA, 2, 1);
		run_file(file_q.size(), 0);
		put_header();
		put_fmt(2, 22050, 16, 0, 0, 1, 0);
		put_chunk(TAG_DATA, 6, 1);
		run_file(file_q.size(), 0);
		put_header();
		put_chunk(TAG_JUNK, 30, 1);
		run_file(file_q.size() - 4, 0);
		put_header();
		put_fmt(1, 32000, 24, 0, 0, 1, 0);
		run_file(file_q.size(), 1);
	endtask

	task automatic test_frame_limit();
		write_reg(rwp_pkg::CFG_FRAME_LIMIT, 32'd2);
		put_header();
		put_fmt(1, 16000, 16, 0, 0, 1, 0);
		put_chunk(TAG_DATA, 6, 1);
		run_file(file_q.size(), 0);
		write_reg(rwp_pkg::CFG_FRAME_LIMIT, 32'd0);
		put_header();
		put_fmt(1, 16000, 16, 0, 0, 1, 0);
		put_chunk(TAG_DATA, 0, 1);
		run_file(file_q.size(), 0);
		write_reg(rwp_pkg::CFG_FRAME_LIMIT, 32'hFFFFFFFF);
	endtask

	task automatic build_random_file();
		int ch, bits, frames, k;
		logic [31:0] rate;
		bit ext;
		ch = $urandom_range(1, 2);
		bits = $urandom_range(0, 1) ? 16 : 24;
		k = $urandom_range(0, 9);
		rate = (k == 0) ? 8000 : (k == 1) ? 192000 : $urandom_range(8000, 192000);
		ext = ($urandom_range(0, 3) == 0);
		frames = $urandom_range(0, 16);
		put_header();
		if ($urandom_range(0, 2) == 0) put_chunk(TAG_JUNK, $urandom_range(0, 7), 1);
		put_fmt(ch, rate, bits, ext, $urandom_range(22, 30), 1, $urandom_range(0, 3));
		if ($urandom_range(0, 4) == 0) put_chunk(TAG_JUNK, $urandom_range(0, 5), 1);
		put_chunk(TAG_DATA, frames * ch * bits / 8, 1);
		if ($urandom_range(0, 3) == 0) put_chunk(TAG_JUNK, $urandom_range(1, 6), 0);
		else repeat ($urandom_range(0, 3)) add_byte(8'($urandom));
		k = $urandom_range(0, 99);
		if (k < 15)
			file_q[$urandom_range(0, file_q.size() - 1)] ^= 8'(1 << $urandom_range(0, 7));
		else if (k < 22)
			file_q[$urandom_range(12, file_q.size() - 1)] = 8'($urandom);
		else if (k < 28)
			foreach (file_q[i]) if (i >= 12) file_q[i] = 8'($urandom);
	endtask

	task automatic test_random();
		int sent, k, len;
		bit held;
		sent = 0;
		held = 1'b0;
		while (sent < 560) begin
			rdy_mode = $urandom_range(0, 2);
			gaps_on = $urandom_range(0, 3) != 0;
			build_random_file();
			len = file_q.size();
			k = $urandom_range(0, 99);
			if (k < 6) len = len - $urandom_range(1, len);
			else if (k < 10) len = len + $urandom_range(1, 4);
			if ($urandom_range(0, 5) == 0)
				write_reg(rwp_pkg::CFG_FRAME_LIMIT, $urandom_range(0, 12));
			else if ($urandom_range(0, 9) == 0)
				write_reg(rwp_pkg::CFG_FRAME_LIMIT, 32'hFFFFFFFF);
			if ($urandom_range(0, 9) == 0)
				write_reg(rwp_pkg::CFG_BYTE_LIMIT, $urandom_range(40, 120));
			else if ($urandom_range(0, 7) == 0)
				write_reg(rwp_pkg::CFG_BYTE_LIMIT, 32'hFFFFFFFF);
			run_file(len, $urandom_range(0, 3));
			sent += file_q.size();
			if (!held && sent > 250) begin
				// hold until the output side catches up
				held = 1'b1;
				drain();
			end
		end
	endtask

	initial begin
		tot_len = 0; byte_lim = 32'hFFFFFFFF; frame_lim = 32'hFFFFFFFF;
		clear_parse();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_valid_files();
		rdy_mode = 2;
		test_header_errors();
		rdy_mode = 1;
		gaps_on = 1'b1;
		test_fmt_errors();
		test_chunk_errors();
		test_frame_limit();
		test_random();
		drain();
		$display("covered %0d files: %0d samples and %0d status transfers checked",
			files_run, samples_seen, statuses_seen);
		$display("with header, fmt, chunk and limit errors, padding and random stalls");
		if (mismatches == 0) $display("tb: success");
		else $display("tb: failure");
		$finish;
	end

endmodule
